// File: hdl/pr_pkg.sv
package pr_pkg;

    localparam int VIDX_W       = 10;
    localparam int MAX_VERTICES = 1024;
    localparam int NCNT_W       = 11;
    localparam int RANK_BITS    = 32;
    localparam int DAMP_W       = 16;
    localparam int ITER_W       = 16;
    localparam int TOL_W        = 31;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 31;
    localparam int PROD_W       = DAMP_W + RANK_BITS;
    localparam int DIFF_W       = RANK_BITS + NCNT_W;
    localparam int DIV_NUM_W    = RANK_BITS;
    localparam int DIV_DEN_W    = 21;

    localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [1:0] CMD_RUN      = 2'd1;
    localparam logic [1:0] CMD_READ     = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;

    localparam logic [1:0] KIND_RANK  = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

endpackage

// File: hdl/pr_if.sv
interface pr_in_if;
    import pr_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [VIDX_W-1:0] source_vertex;
    logic [VIDX_W-1:0] target_vertex;
    modport source (output valid, cmd, source_vertex, target_vertex, input ready);
    modport sink   (input valid, cmd, source_vertex, target_vertex, output ready);
endinterface

interface pr_out_if;
    import pr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [RANK_BITS-1:0] rank_value;
    logic                 converged;
    logic [ITER_W-1:0]    iterations_done;
    logic [1:0]           error_code;
    modport source (output valid, kind, rank_value, converged, iterations_done, error_code,
                    input ready);
    modport sink   (input valid, kind, rank_value, converged, iterations_done, error_code,
                    output ready);
endinterface

// File: hdl/pr_ram.sv
module pr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/pr_div.sv
module pr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pr_pkg::t_div_req          i_req,
    output logic                      o_done,
    output logic [pr_pkg::DIV_NUM_W-1:0] o_quo
);
    import pr_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    // shift one numerator bit into the partial remainder per cycle
    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= CW'(DIV_NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? DIV_DEN_W'(trial - {1'b0, r_den}) : DIV_DEN_W'(trial);
                r_num <= {r_num[DIV_NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

// File: hdl/pagerank_power_iteration.sv
// PageRank power iteration engine.
// Input channel i_in carries one command word: add edge, run, read rank, clear graph.
// Output channel o_res carries one result word: rank reply, run finished, or error.
// Configuration (vertex count, damping Q0.16, iteration limit, tolerance Q0.31) is
// written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only
// while the engine is idle, as the block does not enforce this. Add edge writes the
// edge, then read-modify-writes the out-degree; read rank reads, then registers the
// reply; clear graph sweeps MAX_VERTICES entries; errors return at once. Run: two
// divisions for 1/N and (1-d)/N, then the rank preset; then per iteration copy and
// difference sweeps plus one division per contributing edge, none per skipped edge.
// The per-edge cost is set by the bit-serial divider forming d*prev/outdeg; all rank
// state sits in single-port-read memories, one vertex touched per cycle in the sweeps
// and each edge finished before the next is read. Reset starts a clearing pass over
// the out-degree and rank memories; no word is accepted until it ends.
// One command is in flight at a time. A result waits in the output register while
// o_res.ready is low; a new word is accepted when that register is empty or being
// drained in the same cycle.
module pagerank_power_iteration #(
    parameter int MAX_EDGES = 8192
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pr_in_if.sink                          i_in,
    pr_out_if.source                       o_res,
    input  logic                           i_cfg_we,
    input  logic [pr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pr_pkg::*;

    localparam int EAW    = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_ADD, S_READ, S_INV, S_INV_WAIT, S_JUMP, S_JUMP_WAIT,
        S_INIT, S_COPY, S_EDGE_RD, S_EDGE_SRC, S_EDGE_MUL, S_EDGE_DIV, S_EDGE_WAIT,
        S_DIFF, S_CHECK, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [NCNT_W-1:0] r_vcount;
    logic [DAMP_W-1:0] r_damp;
    logic [ITER_W-1:0] r_max_it;
    logic [TOL_W-1:0]  r_tol;

    // control and datapath registers
    logic [ECNT_W-1:0]    r_ecount;
    logic [ECNT_W-1:0]    r_e;
    logic [NCNT_W-1:0]    r_v;
    logic                 r_pv;
    logic [VIDX_W-1:0]    r_pa;
    logic                 r_clr_rank;
    logic [VIDX_W-1:0]    r_src;
    logic [VIDX_W-1:0]    r_tgt;
    logic                 r_eok;
    logic [RANK_BITS-1:0] r_inv;
    logic [RANK_BITS-1:0] r_jump;
    logic [PROD_W-1:0]    r_prod;
    logic [RANK_BITS-1:0] r_rank_t;
    logic [DIV_DEN_W-1:0] r_deg;
    logic [DIFF_W-1:0]    r_diff;
    logic [ITER_W-1:0]    r_it;
    logic                 r_conv;

    // output register
    logic                 r_ov;
    logic [1:0]           r_kind;
    logic [RANK_BITS-1:0] r_rank_o;
    logic                 r_conv_o;
    logic [ITER_W-1:0]    r_iter_o;
    logic [1:0]           r_err_o;

    // memory ports
    logic                   edge_we;
    logic [2*VIDX_W-1:0]    edge_rdata;
    logic                   deg_we;
    logic [VIDX_W-1:0]      deg_waddr, deg_raddr;
    logic [ECNT_W-1:0]      deg_wdata, deg_rdata;
    logic                   rank_we;
    logic [VIDX_W-1:0]      rank_waddr, rank_raddr;
    logic [RANK_BITS-1:0]   rank_wdata, rank_rdata;
    logic [VIDX_W-1:0]      prev_raddr;
    logic [RANK_BITS-1:0]   prev_rdata;

    t_div_req             div_req;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic                 in_acc;
    logic                 out_free;
    logic [NCNT_W-1:0]    n_eff;
    logic                 add_range_ok;
    logic                 add_room;
    logic [RANK_BITS:0]   sum_t;
    logic [RANK_BITS-1:0] sat_t;
    logic [RANK_BITS-1:0] abs_d;
    logic [VIDX_W-1:0]    e_src, e_tgt;

    assign out_free = !r_ov || o_res.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_acc = i_in.valid && i_in.ready;

    // clamp N to 1..MAX_VERTICES
    always_comb begin
        if (r_vcount == '0) begin
            n_eff = NCNT_W'(1);
        end else if (r_vcount > NCNT_W'(MAX_VERTICES)) begin
            n_eff = NCNT_W'(MAX_VERTICES);
        end else begin
            n_eff = r_vcount;
        end
    end

    assign add_range_ok = ({1'b0, i_in.source_vertex} < n_eff) &&
                          ({1'b0, i_in.target_vertex} < n_eff);
    assign add_room     = r_ecount < ECNT_W'(MAX_EDGES);
    assign e_src        = edge_rdata[2*VIDX_W-1:VIDX_W];
    assign e_tgt        = edge_rdata[VIDX_W-1:0];

    // saturating rank accumulate
    assign sum_t = {1'b0, r_rank_t} + {1'b0, div_quo};
    assign sat_t = sum_t[RANK_BITS] ? {RANK_BITS{1'b1}} : sum_t[RANK_BITS-1:0];
    assign abs_d = (rank_rdata >= prev_rdata) ? rank_rdata - prev_rdata
                                              : prev_rdata - rank_rdata;

    assign edge_we = in_acc && (i_in.cmd == CMD_ADD_EDGE) && add_range_ok && add_room;

    always_comb begin
        deg_we     = 1'b0;
        deg_waddr  = r_src;
        deg_wdata  = deg_rdata + 1'b1;
        deg_raddr  = r_src;
        rank_we    = 1'b0;
        rank_waddr = r_pa;
        rank_wdata = r_jump;
        rank_raddr = r_v[VIDX_W-1:0];
        prev_raddr = r_v[VIDX_W-1:0];
        div_req    = '{start: 1'b0, num: r_prod[PROD_W-1:DAMP_W], den: r_deg};
        case (r_state)
            S_CLEAR: begin
                deg_we     = 1'b1;
                deg_waddr  = r_v[VIDX_W-1:0];
                deg_wdata  = '0;
                rank_we    = r_clr_rank;
                rank_waddr = r_v[VIDX_W-1:0];
                rank_wdata = '0;
            end
            S_IDLE: begin
                deg_raddr  = i_in.source_vertex;
                rank_raddr = i_in.target_vertex;
            end
            S_ADD: begin
                deg_we = 1'b1;
            end
            S_INV: begin
                div_req = '{start: 1'b1, num: DIV_NUM_W'(1) << (RANK_BITS - 1),
                            den: DIV_DEN_W'(n_eff)};
            end
            S_JUMP: begin
                div_req = '{start: 1'b1,
                            num: {17'h10000 - {1'b0, r_damp}, {(RANK_BITS - 17){1'b0}}},
                            den: DIV_DEN_W'(n_eff)};
            end
            S_INIT: begin
                rank_we    = 1'b1;
                rank_waddr = r_v[VIDX_W-1:0];
                rank_wdata = r_inv;
            end
            S_COPY: begin
                rank_we = r_pv;
            end
            S_EDGE_SRC: begin
                deg_raddr  = e_src;
                prev_raddr = e_src;
                rank_raddr = e_tgt;
            end
            S_EDGE_DIV: begin
                div_req.start = 1'b1;
            end
            S_EDGE_WAIT: begin
                rank_we    = div_done;
                rank_waddr = r_tgt;
                rank_wdata = sat_t;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_rank <= 1'b1;
            r_v        <= '0;
            r_pv       <= 1'b0;
            r_ecount   <= '0;
            r_ov       <= 1'b0;
            r_vcount   <= NCNT_W'(1);
            r_damp     <= DAMP_W'(55706);
            r_max_it   <= ITER_W'(100);
            r_tol      <= TOL_W'(2147);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VERTEX_COUNT: r_vcount <= i_cfg_data[NCNT_W-1:0];
                    REG_DAMPING:      r_damp   <= i_cfg_data[DAMP_W-1:0];
                    REG_MAX_ITER:     r_max_it <= i_cfg_data[ITER_W-1:0];
                    REG_TOLERANCE:    r_tol    <= i_cfg_data[TOL_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_v <= r_v + 1'b1;
                    if (r_v == NCNT_W'(MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_src <= i_in.source_vertex;
                        case (i_in.cmd)
                            CMD_ADD_EDGE: begin
                                if (!add_range_ok) begin
                                    r_ov <= 1'b1; r_kind <= KIND_ERROR; r_rank_o <= '0;
                                    r_conv_o <= 1'b0; r_iter_o <= '0; r_err_o <= ERR_RANGE;
                                end else if (!add_room) begin
                                    r_ov <= 1'b1; r_kind <= KIND_ERROR; r_rank_o <= '0;
                                    r_conv_o <= 1'b0; r_iter_o <= '0; r_err_o <= ERR_FULL;
                                end else begin
                                    r_state <= S_ADD;
                                end
                            end
                            CMD_RUN: begin
                                r_state <= S_INV;
                            end
                            CMD_READ: begin
                                if ({1'b0, i_in.target_vertex} >= n_eff) begin
                                    r_ov <= 1'b1; r_kind <= KIND_ERROR; r_rank_o <= '0;
                                    r_conv_o <= 1'b0; r_iter_o <= '0; r_err_o <= ERR_RANGE;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                // clear graph: drop edges and out-degrees, keep ranks
                                r_ecount   <= '0;
                                r_clr_rank <= 1'b0;
                                r_v        <= '0;
                                r_state    <= S_CLEAR;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    r_ecount <= r_ecount + 1'b1;
                    r_state  <= S_IDLE;
                end
                S_READ: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_kind <= KIND_RANK; r_rank_o <= rank_rdata;
                        r_conv_o <= 1'b0; r_iter_o <= '0; r_err_o <= ERR_NONE;
                        r_state <= S_IDLE;
                    end
                end
                S_INV: begin
                    r_it    <= '0;
                    r_conv  <= 1'b0;
                    r_state <= S_INV_WAIT;
                end
                S_INV_WAIT: begin
                    if (div_done) begin
                        r_inv   <= div_quo;
                        r_state <= S_JUMP;
                    end
                end
                S_JUMP: begin
                    r_state <= S_JUMP_WAIT;
                end
                S_JUMP_WAIT: begin
                    if (div_done) begin
                        r_jump  <= div_quo;
                        r_v     <= '0;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_v <= r_v + 1'b1;
                    if (r_v == n_eff - 1'b1) begin
                        r_v  <= '0;
                        r_pv <= 1'b0;
                        r_state <= (r_max_it == '0) ? S_DONE : S_COPY;
                    end
                end
                S_COPY: begin
                    // read rank[v]; in the next cycle store it as prev and preset rank to jump
                    r_pv <= r_v < n_eff;
                    r_pa <= r_v[VIDX_W-1:0];
                    if (r_v < n_eff) begin
                        r_v <= r_v + 1'b1;
                    end else if (!r_pv) begin
                        r_v    <= '0;
                        r_e    <= '0;
                        r_diff <= '0;
                        r_state <= (r_ecount == '0) ? S_DIFF : S_EDGE_RD;
                    end
                end
                S_EDGE_RD: begin
                    r_state <= S_EDGE_SRC;
                end
                S_EDGE_SRC: begin
                    r_src   <= e_src;
                    r_tgt   <= e_tgt;
                    r_eok   <= ({1'b0, e_src} < n_eff) && ({1'b0, e_tgt} < n_eff);
                    r_state <= S_EDGE_MUL;
                end
                S_EDGE_MUL: begin
                    if (!r_eok || deg_rdata == '0) begin
                        r_e <= r_e + 1'b1;
                        r_state <= (r_e + 1'b1 == r_ecount) ? S_DIFF : S_EDGE_RD;
                    end else begin
                        r_prod   <= r_damp * prev_rdata;
                        r_rank_t <= rank_rdata;
                        r_deg    <= DIV_DEN_W'(deg_rdata);
                        r_state  <= S_EDGE_DIV;
                    end
                end
                S_EDGE_DIV: begin
                    r_state <= S_EDGE_WAIT;
                end
                S_EDGE_WAIT: begin
                    if (div_done) begin
                        r_e <= r_e + 1'b1;
                        r_state <= (r_e + 1'b1 == r_ecount) ? S_DIFF : S_EDGE_RD;
                    end
                end
                S_DIFF: begin
                    r_pv <= r_v < n_eff;
                    if (r_pv) begin
                        r_diff <= r_diff + DIFF_W'(abs_d);
                    end
                    if (r_v < n_eff) begin
                        r_v <= r_v + 1'b1;
                    end else if (!r_pv) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_it <= r_it + 1'b1;
                    r_v  <= '0;
                    r_pv <= 1'b0;
                    if (r_diff < DIFF_W'(r_tol)) begin
                        r_conv  <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_it + 1'b1 == r_max_it) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_COPY;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_kind <= KIND_RUN; r_rank_o <= '0;
                        r_conv_o <= r_conv; r_iter_o <= r_it; r_err_o <= ERR_NONE;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.kind            = r_kind;
    assign o_res.rank_value      = r_rank_o;
    assign o_res.converged       = r_conv_o;
    assign o_res.iterations_done = r_iter_o;
    assign o_res.error_code      = r_err_o;

    pr_ram #(.WIDTH(2 * VIDX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_ecount[EAW-1:0]),
        .i_wdata ({i_in.source_vertex, i_in.target_vertex}),
        .i_raddr (r_e[EAW-1:0]),
        .o_rdata (edge_rdata)
    );

    pr_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (deg_waddr),
        .i_wdata (deg_wdata),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    pr_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_VERTICES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_raddr (rank_raddr),
        .o_rdata (rank_rdata)
    );

    pr_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_VERTICES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_COPY && r_pv),
        .i_waddr (r_pa),
        .i_wdata (rank_rdata),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    pr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );
endmodule

// File: hdl/pr_chk.sv
module pr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_cmd,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [31:0] i_rank_value,
    input logic        i_converged,
    input logic [15:0] i_iterations_done,
    input logic [1:0]  i_error_code
);
    import pr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) &&
        $stable(i_rank_value) && $stable(i_iterations_done) && $stable(i_error_code))
        else $error("result changed while stalled");

    // a run command keeps the engine busy on the next cycle
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_cmd == CMD_RUN |=> !i_in_ready)
        else $error("word accepted right after run");

    a_rank_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_RANK |->
        !i_converged && i_iterations_done == '0 && i_error_code == ERR_NONE)
        else $error("rank reply carries stray fields");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_ERROR |->
        i_error_code != ERR_NONE && i_rank_value == '0 && !i_converged)
        else $error("malformed error word");

    a_run_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_RUN |-> i_rank_value == '0 &&
        i_error_code == ERR_NONE && (i_iterations_done != '0 || !i_converged))
        else $error("malformed run word");
endmodule

bind pagerank_power_iteration pr_chk u_pr_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_cmd          (i_in.cmd),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_kind            (o_res.kind),
    .i_rank_value      (o_res.rank_value),
    .i_converged       (o_res.converged),
    .i_iterations_done (o_res.iterations_done),
    .i_error_code      (o_res.error_code)
);

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pr_pkg::*;

    typedef struct {
        logic [1:0]           kind;
        logic [RANK_BITS-1:0] rank_value;
        logic                 converged;
        logic [ITER_W-1:0]    iterations_done;
        logic [1:0]           error_code;
    } t_rank_reply;

    localparam int EDGE_DEPTH = 8192;

    // Mirror of the engine: graph store, ranks, registers, and the replies
    // still owed on the result channel.
    class t_rank_board;
        logic [NCNT_W-1:0]   vertex_reg;
        logic [DAMP_W-1:0]   damping_reg;
        logic [ITER_W-1:0]   iter_limit_reg;
        logic [TOL_W-1:0]    tolerance_reg;
        logic [VIDX_W-1:0]   edge_src[EDGE_DEPTH];
        logic [VIDX_W-1:0]   edge_dst[EDGE_DEPTH];
        int unsigned         edge_total;
        int unsigned         out_degree[MAX_VERTICES];
        longint unsigned     rank_now[MAX_VERTICES];
        longint unsigned     rank_prev[MAX_VERTICES];
        t_rank_reply         owed_replies[$];
        int                  mismatches;

        function new();
            vertex_reg     = 1;
            damping_reg    = 55706;
            iter_limit_reg = 100;
            tolerance_reg  = 2147;
            edge_total     = 0;
            mismatches     = 0;
            foreach (out_degree[i]) out_degree[i] = 0;
            foreach (rank_now[i]) rank_now[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_VERTEX_COUNT: vertex_reg     = data[NCNT_W-1:0];
                REG_DAMPING:      damping_reg    = data[DAMP_W-1:0];
                REG_MAX_ITER:     iter_limit_reg = data[ITER_W-1:0];
                default:          tolerance_reg  = data[TOL_W-1:0];
            endcase
        endfunction

        function int unsigned active_n();
            if (vertex_reg == 0) return 1;
            if (vertex_reg > MAX_VERTICES) return MAX_VERTICES;
            return vertex_reg;
        endfunction

        function void owe(logic [1:0] k, longint unsigned r, bit c, int unsigned it,
                          logic [1:0] e);
            t_rank_reply rep;
            rep.kind            = k;
            rep.rank_value      = r[RANK_BITS-1:0];
            rep.converged       = c;
            rep.iterations_done = it[ITER_W-1:0];
            rep.error_code      = e;
            owed_replies.push_back(rep);
        endfunction

        // Power iteration from a uniform start, exactly as the engine does it.
        function void iterate_ranks();
            int unsigned     n;
            longint unsigned d, jump, diff, c, r;
            int unsigned     it, done, s, t;
            bit              conv;
            n    = active_n();
            d    = damping_reg;
            jump = ((65536 - d) * (64'd1 << 15)) / n;
            done = 0;
            conv = 0;
            for (int v = 0; v < n; v++) rank_now[v] = (64'd1 << 31) / n;
            for (it = 0; it < iter_limit_reg; it++) begin
                diff = 0;
                for (int v = 0; v < n; v++) begin
                    rank_prev[v] = rank_now[v];
                    rank_now[v]  = jump;
                end
                for (int e = 0; e < edge_total; e++) begin
                    s = edge_src[e];
                    t = edge_dst[e];
                    if (s >= n || t >= n || out_degree[s] == 0) continue;
                    c = (d * rank_prev[s]) / (64'd65536 * out_degree[s]);
                    r = rank_now[t] + c;
                    rank_now[t] = (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
                end
                for (int v = 0; v < n; v++)
                    diff += (rank_now[v] > rank_prev[v]) ? rank_now[v] - rank_prev[v]
                                                         : rank_prev[v] - rank_now[v];
                done = it + 1;
                if (diff < tolerance_reg) begin
                    conv = 1;
                    break;
                end
            end
            owe(KIND_RUN, 0, conv, done, ERR_NONE);
        endfunction

        function void note_word(logic [1:0] cmd, logic [VIDX_W-1:0] src,
                                logic [VIDX_W-1:0] dst);
            int unsigned n;
            n = active_n();
            case (cmd)
                CMD_ADD_EDGE: begin
                    if (src >= n || dst >= n) owe(KIND_ERROR, 0, 0, 0, ERR_RANGE);
                    else if (edge_total >= EDGE_DEPTH) owe(KIND_ERROR, 0, 0, 0, ERR_FULL);
                    else begin
                        edge_src[edge_total] = src;
                        edge_dst[edge_total] = dst;
                        edge_total++;
                        out_degree[src]++;
                    end
                end
                CMD_RUN: iterate_ranks();
                CMD_READ: begin
                    if (dst >= n) owe(KIND_ERROR, 0, 0, 0, ERR_RANGE);
                    else owe(KIND_RANK, rank_now[dst], 0, 0, ERR_NONE);
                end
                default: begin
                    edge_total = 0;
                    foreach (out_degree[i]) out_degree[i] = 0;
                end
            endcase
        endfunction

        function void check_result(t_rank_reply got);
            t_rank_reply want;
            if (owed_replies.size() == 0) begin
                $display("%0t: unexpected result kind=%0d rank=%h conv=%0d iters=%0d err=%0d",
                         $time, got.kind, got.rank_value, got.converged,
                         got.iterations_done, got.error_code);
                mismatches++;
                return;
            end
            want = owed_replies.pop_front();
            if (got.kind !== want.kind || got.rank_value !== want.rank_value ||
                got.converged !== want.converged ||
                got.iterations_done !== want.iterations_done ||
                got.error_code !== want.error_code) begin
                $display("%0t: mismatch expected kind=%0d rank=%h conv=%0d iters=%0d err=%0d",
                         $time, want.kind, want.rank_value, want.converged,
                         want.iterations_done, want.error_code);
                $display("%0t:          actual   kind=%0d rank=%h conv=%0d iters=%0d err=%0d",
                         $time, got.kind, got.rank_value, got.converged,
                         got.iterations_done, got.error_code);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    no_stall;   // phase runs back to back with no gaps
    int                    ready_hold;
    t_rank_board           board;

    pr_in_if  word_ch();
    pr_out_if res_ch();

    pagerank_power_iteration uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (word_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Overall time budget: runs are kept small, so this is many times the slowest pass.
    initial begin
        #200_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Sample both channels at the rising edge. Retire results before noting the
    // new word: a word accepted at this edge cannot have produced a result yet.
    always @(posedge i_clk) begin
        t_rank_reply got;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.kind            = res_ch.kind;
                got.rank_value      = res_ch.rank_value;
                got.converged       = res_ch.converged;
                got.iterations_done = res_ch.iterations_done;
                got.error_code      = res_ch.error_code;
                board.check_result(got);
            end
            if (word_ch.valid && word_ch.ready)
                board.note_word(word_ch.cmd, word_ch.source_vertex, word_ch.target_vertex);
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_stall) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Result-side back pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            res_ch.ready <= 1'b0;
        end else if (no_stall || $urandom_range(0, 99) < 65) begin
            res_ch.ready <= 1'b1;
        end else begin
            ready_hold = pick_gap();
            res_ch.ready <= 1'b0;
        end
    end

    // Present one word after a random gap and hold it until accepted.
    task automatic send_word(logic [1:0] cmd, logic [VIDX_W-1:0] src,
                             logic [VIDX_W-1:0] dst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            word_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        word_ch.valid         <= 1'b1;
        word_ch.cmd           <= cmd;
        word_ch.source_vertex <= src;
        word_ch.target_vertex <= dst;
        do @(posedge i_clk); while (!word_ch.ready);
    endtask

    // Drop valid, let every owed reply arrive, then cover a clear graph sweep.
    task automatic settle();
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
        while (board.owed_replies.size() != 0) @(posedge i_clk);
        repeat (MAX_VERTICES + 100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic write_all(int n, int d, int it, int tol);
        write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(n));
        write_reg(REG_DAMPING, CFG_DATA_W'(d));
        write_reg(REG_MAX_ITER, CFG_DATA_W'(it));
        write_reg(REG_TOLERANCE, CFG_DATA_W'(tol));
    endtask

    function automatic logic [VIDX_W-1:0] any_vertex(int n);
        return VIDX_W'($urandom_range(0, n - 1));
    endfunction

    initial begin
        int n, r, it_cap;
        board         = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        no_stall      = 1'b0;
        ready_hold    = 0;
        word_ch.valid = 1'b0;
        word_ch.cmd   = CMD_READ;
        word_ch.source_vertex = '0;
        word_ch.target_vertex = '0;
        res_ch.ready  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        // Hold off until the clearing pass after reset is over.
        repeat (MAX_VERTICES + 100) @(posedge i_clk);

        // Directed: reset registers, read before any run, range errors, self loop.
        send_word(CMD_READ, 0, 0);
        send_word(CMD_READ, 0, 1023);
        send_word(CMD_ADD_EDGE, 1, 0);
        send_word(CMD_ADD_EDGE, 0, 0);
        send_word(CMD_RUN, 0, 0);
        send_word(CMD_READ, 0, 0);
        send_word(CMD_CLEAR, 0, 0);
        settle();

        // Small chain with a shortcut and an out-of-range edge, full damping, one iteration.
        write_all(4, 65535, 1, 32'h7FFF_FFFF);
        send_word(CMD_ADD_EDGE, 0, 1);
        send_word(CMD_ADD_EDGE, 1, 2);
        send_word(CMD_ADD_EDGE, 2, 3);
        send_word(CMD_ADD_EDGE, 0, 3);
        send_word(CMD_ADD_EDGE, 3, 1023);
        send_word(CMD_RUN, 0, 0);
        send_word(CMD_READ, 0, 0);
        send_word(CMD_READ, 0, 3);
        settle();

        // No iterations, zero damping and zero tolerance.
        write_all(4, 0, 0, 0);
        send_word(CMD_RUN, 0, 0);
        send_word(CMD_READ, 0, 2);
        settle();

        // Shrink N: edges past it stop contributing; reads past it fail.
        write_all(2, 55706, 5, 0);
        send_word(CMD_RUN, 0, 0);
        send_word(CMD_READ, 0, 1);
        send_word(CMD_READ, 0, 3);
        settle();

        // Largest iteration limit with a trivially settling graph.
        write_all(1, 1, 65535, 1);
        send_word(CMD_CLEAR, 0, 0);
        send_word(CMD_RUN, 0, 0);
        settle();

        // Clamped vertex counts at both ends.
        write_all(2047, 65535, 2, 32'h7FFF_FFFF);
        send_word(CMD_ADD_EDGE, 1023, 512);
        send_word(CMD_ADD_EDGE, 512, 1023);
        send_word(CMD_RUN, 0, 0);
        send_word(CMD_READ, 0, 1023);
        send_word(CMD_CLEAR, 0, 0);
        settle();
        write_all(0, 32768, 3, 1000);
        send_word(CMD_RUN, 0, 0);
        send_word(CMD_READ, 0, 1023);
        send_word(CMD_READ, 0, 700);
        settle();

        // Load edges back to back, then a source out of range.
        no_stall = 1'b1;
        write_reg(REG_VERTEX_COUNT, 2);
        for (int i = 0; i < 64; i++)
            send_word(CMD_ADD_EDGE, VIDX_W'($urandom_range(0, 1)),
                      VIDX_W'($urandom_range(0, 1)));
        no_stall = 1'b0;
        send_word(CMD_ADD_EDGE, 0, 1);
        send_word(CMD_ADD_EDGE, 2, 0);
        send_word(CMD_READ, 0, 1);
        send_word(CMD_CLEAR, 0, 0);
        settle();

        // Random phases: fresh registers and an empty graph, then a mix of words.
        for (int ph = 0; ph < 10; ph++) begin
            r = $urandom_range(0, 99);
            if (r < 75)      n = $urandom_range(1, 12);
            else if (r < 85) n = $urandom_range(0, 2047);
            else             n = $urandom_range(13, 64);
            it_cap = (n > 64 || n == 0) ? 3 : 20;
            r = $urandom_range(0, 9);
            write_all(n,
                      (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535),
                      $urandom_range(0, it_cap),
                      (r == 2) ? 0 : (r < 6) ? $urandom_range(0, 100000)
                                             : $urandom_range(0, 32'h7FFF_FFFF));
            no_stall = ($urandom_range(0, 3) == 0);
            n = board.active_n();
            send_word(CMD_CLEAR, 0, 0);
            for (int i = 0; i < 100; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45)      send_word(CMD_ADD_EDGE, any_vertex(n), any_vertex(n));
                else if (r < 52) send_word(CMD_ADD_EDGE, VIDX_W'($urandom),
                                           VIDX_W'($urandom));
                else if (r < 82) send_word(CMD_READ, VIDX_W'($urandom), any_vertex(n));
                else if (r < 87) send_word(CMD_READ, VIDX_W'($urandom), VIDX_W'($urandom));
                else if (r < 92) send_word(CMD_RUN, VIDX_W'($urandom), VIDX_W'($urandom));
                else             send_word(CMD_CLEAR, VIDX_W'($urandom), VIDX_W'($urandom));
            end
            settle();
        end

        if (board.owed_replies.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     board.owed_replies.size());
            board.mismatches++;
        end
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
